// ----- src/box_average_downscale_defines.svh -----
// Assertion macros used by the top-level RTL file of the block.
`ifndef BOX_AVERAGE_DOWNSCALE_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define BAD_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define BAD_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ----- src/bad_pkg.sv -----
// Package with the constants, state codes and types of the downscaler.
`default_nettype none
package bad_pkg;
  localparam int unsigned MaxThumb = 64;
  localparam int unsigned MaxDim = 4096;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CROW  = 4'd1;
  localparam logic [3:0] ST_CCOL  = 4'd2;
  localparam logic [3:0] ST_NROW  = 4'd3;
  localparam logic [3:0] ST_ACC   = 4'd4;
  localparam logic [3:0] ST_ERD   = 4'd5;
  localparam logic [3:0] ST_EDIV  = 4'd6;
  localparam logic [3:0] ST_EOUT  = 4'd7;
  localparam logic [3:0] ST_CLR   = 4'd8;
  localparam logic [3:0] ST_ELAT  = 4'd9;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THUMB  = 2'd2;
  localparam logic [1:0] REG_COMPS  = 2'd3;

  typedef struct packed {
    logic        start;
    logic [19:0] dividend;
    logic [12:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- src/box_average_downscale.sv -----
// Box-filter area-average downscaler to a square thumbnail, top level.
// Each pixel runs three passes of the shared divider (cell row, cell column, next-row cell
// row) and then a read-modify-write of the band memory.
// A band end reads each cell column, divides each used component with a nonzero count and
// zeroes the rest, then sends the word, waiting while it stalls; then a band memory clear.
// Reset or a register write starts that clear with s_axis_tready low; regs reset 64, 64, 8, 3.
`default_nettype none
`include "box_average_downscale_defines.svh"
module box_average_downscale (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // comp0, comp1, comp2, comp3
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [47:0] m_axis_tdata,  // avg0..avg3, cell_row, cell_column, 4 pad
  output      logic        m_axis_tlast,  // last_of_band
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);
  import bad_pkg::*;

  logic [12:0] width_q, height_q;
  logic [6:0]  thumb_q;
  logic [2:0]  comps_q;
  logic [12:0] w, h;
  logic [6:0]  t;
  logic [19:0] t_ext;
  logic [2:0]  nc;

  logic [3:0]  st_q, st_d;
  logic [11:0] col_q, col_d, row_q, row_d;
  logic [5:0]  crow_q, crow_d, ccol_q, ccol_d, addr_q, addr_d;
  logic [1:0]  k_q, k_d;
  logic [31:0] pix_q;
  logic [31:0] sel_sum;
  logic [7:0]  avg_q [4];
  logic        band_end_q, band_end_d;
  logic        ovalid_q;
  logic [152:0] rdata, wdata;
  logic        we;
  logic [5:0]  maddr;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        wide;
  logic        accept, cfg_acc;

  assign w  = (width_q == 13'd0) ? 13'd1 : ((width_q > 13'(MaxDim)) ? 13'(MaxDim) : width_q);
  assign h  = (height_q == 13'd0) ? 13'd1 : ((height_q > 13'(MaxDim)) ? 13'(MaxDim) : height_q);
  assign t  = (thumb_q == 7'd0) ? 7'd1 : ((thumb_q > 7'(MaxThumb)) ? 7'(MaxThumb) : thumb_q);
  assign nc = (comps_q == 3'd0) ? 3'd1 : ((comps_q > 3'd4) ? 3'd4 : comps_q);
  assign t_ext = {13'd0, t};

  // A pending configuration write keeps the pixel input closed so the two never collide.
  assign cfg_ready_o   = (st_q == ST_IDLE);
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (st_q == ST_IDLE) && !cfg_valid_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    unique case (k_q)
      2'd0:    sel_sum = rdata[31:0];
      2'd1:    sel_sum = rdata[63:32];
      2'd2:    sel_sum = rdata[95:64];
      default: sel_sum = rdata[127:96];
    endcase
  end

  always_comb begin
    st_d = st_q; col_d = col_q; row_d = row_q; crow_d = crow_q; ccol_d = ccol_q;
    addr_d = addr_q; k_d = k_q; band_end_d = band_end_q;
    dreq = '0; wide = 1'b0; we = 1'b0; wdata = '0; maddr = addr_q;
    unique case (st_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          col_d = '0; row_d = '0; addr_d = '0; st_d = ST_CLR;
        end else if (accept) begin
          if ({1'b0, col_q} >= w) col_d = '0;
          if ({1'b0, row_q} >= h) row_d = '0;
          dreq.start = 1'b1;
          dreq.dividend = t_ext * {8'd0, (({1'b0, row_q} >= h) ? 12'd0 : row_q)};
          dreq.divisor = h;
          st_d = ST_CROW;
        end
      end
      ST_CROW: if (drsp.done) begin
        crow_d = drsp.quotient[5:0];
        dreq.start = 1'b1; dreq.dividend = t_ext * {8'd0, col_q}; dreq.divisor = w;
        st_d = ST_CCOL;
      end
      ST_CCOL: if (drsp.done) begin
        ccol_d = (drsp.quotient > 32'd63) ? 6'd63 : drsp.quotient[5:0];
        dreq.start = 1'b1; dreq.dividend = t_ext * {7'd0, {1'b0, row_q} + 13'd1};
        dreq.divisor = h;
        st_d = ST_NROW;
      end
      ST_NROW: if (drsp.done) begin
        band_end_d = ({1'b0, row_q} + 13'd1 >= h) || (drsp.quotient[6:0] != {1'b0, crow_q});
        addr_d = ccol_q;
        st_d = ST_ACC;
      end
      ST_ACC: begin
        // Wait for the registered read, then write back.
        if (k_q == 2'd0) begin
          k_d = 2'd1;
        end else begin
          k_d = 2'd0;
          we = 1'b1;
          wdata[152:128] = rdata[152:128] + 25'd1;
          wdata[31:0]   = rdata[31:0] + {24'd0, pix_q[7:0]};
          wdata[63:32]  = rdata[63:32] + ((nc > 3'd1) ? {24'd0, pix_q[15:8]} : 32'd0);
          wdata[95:64]  = rdata[95:64] + ((nc > 3'd2) ? {24'd0, pix_q[23:16]} : 32'd0);
          wdata[127:96] = rdata[127:96] + ((nc > 3'd3) ? {24'd0, pix_q[31:24]} : 32'd0);
          if ({1'b0, col_q} + 13'd1 < w) begin
            col_d = col_q + 12'd1; st_d = ST_IDLE;
          end else begin
            col_d = '0;
            row_d = band_end_q && ({1'b0, row_q} + 13'd1 >= h) ? 12'd0 : row_q + 12'd1;
            if (band_end_q) begin
              addr_d = '0; st_d = ST_ERD;
            end else begin
              st_d = ST_IDLE;
            end
          end
        end
      end
      ST_ERD: begin
        k_d = 2'd0; st_d = ST_ELAT;
      end
      ST_ELAT: begin
        if ({1'b0, k_q} < nc && rdata[152:128] != 25'd0) begin
          dreq.start = 1'b1; wide = 1'b1; st_d = ST_EDIV;
        end else begin
          st_d = (k_q == 2'd3) ? ST_EOUT : ST_ELAT;
          k_d = k_q + 2'd1;
        end
      end
      ST_EDIV: if (drsp.done) begin
        st_d = (k_q == 2'd3) ? ST_EOUT : ST_ELAT;
        k_d = k_q + 2'd1;
      end
      ST_EOUT: if (!ovalid_q) begin
        if ({1'b0, addr_q} + 7'd1 >= t) begin
          addr_d = '0; st_d = ST_CLR;
        end else begin
          addr_d = addr_q + 6'd1; st_d = ST_ERD;
        end
      end
      ST_CLR: begin
        we = 1'b1;
        addr_d = addr_q + 6'd1;
        if (addr_q == 6'd63) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  bad_div u_div (
    .clk_i, .rst_ni, .req_i(dreq),
    .wide_dividend_i(sel_sum), .wide_divisor_i(rdata[152:128]), .wide_i(wide),
    .rsp_o(drsp)
  );

  bad_band_mem u_mem (
    .clk_i, .we_i(we), .addr_i(maddr), .wdata_i(wdata), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 13'd64; height_q <= 13'd64; thumb_q <= 7'd8; comps_q <= 3'd3;
      st_q <= ST_CLR; col_q <= '0; row_q <= '0; addr_q <= '0; k_q <= '0;
      band_end_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; col_q <= col_d; row_q <= row_d; addr_q <= addr_d; k_q <= k_d;
      band_end_q <= band_end_d;
      if (cfg_acc) begin
        unique case (cfg_index_i)
          REG_WIDTH:  width_q  <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i;
          REG_THUMB:  thumb_q  <= cfg_data_i[6:0];
          REG_COMPS:  comps_q  <= cfg_data_i[2:0];
          default:    ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      else if (st_q == ST_EOUT && !ovalid_q) ovalid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    crow_q <= crow_d; ccol_q <= ccol_d;
    if (accept) pix_q <= s_axis_tdata;
    if (st_q == ST_ELAT && !({1'b0, k_q} < nc && rdata[152:128] != 25'd0)) avg_q[k_q] <= 8'd0;
    if (st_q == ST_EDIV && drsp.done) avg_q[k_q] <= drsp.quotient[7:0];
    if (st_q == ST_EOUT && !ovalid_q) begin
      m_axis_tdata <= {4'd0, addr_q, crow_q, avg_q[3], avg_q[2], avg_q[1], avg_q[0]};
      m_axis_tlast <= ({1'b0, addr_q} + 7'd1 >= t);
    end
  end

  assign m_axis_tvalid = ovalid_q;

  `BAD_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, st_q != ST_IDLE, !s_axis_tready)
  `BAD_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `BAD_ASSERT_NEXT(a_cfg_clears, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, st_q == ST_CLR)
endmodule
`default_nettype wire

// ----- src/bad_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module bad_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bad_pkg::div_req_t req_i,
  input  wire logic [31:0]       wide_dividend_i,
  input  wire logic [24:0]       wide_divisor_i,
  input  wire logic              wide_i,
  output      bad_pkg::div_rsp_t rsp_o
);
  import bad_pkg::*;
  logic [31:0] quo_q, quo_d;
  logic [24:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [25:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[31]};
    if (req_i.start) begin
      quo_d = wide_i ? wide_dividend_i : {12'd0, req_i.dividend};
      dvs_d = wide_i ? wide_divisor_i : {12'd0, req_i.divisor};
      rem_d = '0; cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 25'(trial - {1'b0, dvs_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[24:0];
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

// ----- src/bad_band_mem.sv -----
// Band accumulator memory: four component sums and a pixel count per cell column.
`default_nettype none
module bad_band_mem (
  input  wire logic         clk_i,
  input  wire logic         we_i,
  input  wire logic [5:0]   addr_i,
  input  wire logic [152:0] wdata_i,
  output      logic [152:0] rdata_o
);
  import bad_pkg::*;
  logic [152:0] mem [MaxThumb];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ----- verif/box_average_downscale_tb.sv -----
// Self-checking testbench for the box-average thumbnail downscaler.
`timescale 1ns / 100ps
module box_average_downscale_tb;
  import bad_pkg::*;

  typedef struct {
    bit [7:0] avg [4];
    bit [5:0] cell_row;
    bit [5:0] cell_column;
    bit       last_of_band;
  } cell_avg_t;

  // Tracks the band sums and emits the expected cell averages in order.
  class cell_average_predictor;
    int unsigned reg_w, reg_h, reg_t, reg_nc;
    int unsigned col_pos, row_pos;
    bit [31:0]   sums [4][MaxThumb];
    bit [24:0]   counts [MaxThumb];
    cell_avg_t   expected_cells [$];
    int unsigned failures;

    function new();
      reg_w = 64; reg_h = 64; reg_t = 8; reg_nc = 3;
      failures = 0;
      restart();
    endfunction

    function void restart();
      col_pos = 0;
      row_pos = 0;
      clear_band();
    endfunction

    function void clear_band();
      for (int c = 0; c < MaxThumb; c++) begin
        counts[c] = '0;
        for (int k = 0; k < 4; k++) sums[k][c] = '0;
      end
    endfunction

    function int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] v);
      case (idx)
        REG_WIDTH:  reg_w = v;
        REG_HEIGHT: reg_h = v;
        REG_THUMB:  reg_t = v[6:0];
        REG_COMPS:  reg_nc = v[2:0];
        default: ;
      endcase
      restart();
    endfunction

    function void note_pixel(bit [31:0] pix);
      int unsigned w, h, t, nc, col, row, crow, ccol;
      bit last_row, band_end;
      cell_avg_t e;
      w = sat(reg_w, 1, MaxDim);
      h = sat(reg_h, 1, MaxDim);
      t = sat(reg_t, 1, MaxThumb);
      nc = sat(reg_nc, 1, 4);
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      col = col_pos;
      row = row_pos;
      crow = (t * row) / h;
      ccol = (t * col) / w;
      if (ccol >= MaxThumb) ccol = MaxThumb - 1;
      counts[ccol] = counts[ccol] + 1;
      for (int k = 0; k < nc; k++) sums[k][ccol] += pix[8*k +: 8];
      if (col + 1 < w) begin
        col_pos = col + 1;
        return;
      end
      col_pos = 0;
      last_row = (row + 1 >= h);
      band_end = last_row || ((t * (row + 1)) / h != crow);
      row_pos = last_row ? 0 : row + 1;
      if (!band_end) return;
      for (int c = 0; c < t; c++) begin
        for (int k = 0; k < 4; k++)
          e.avg[k] = (k < nc && counts[c] != 0) ? 8'(sums[k][c] / counts[c]) : 8'd0;
        e.cell_row = crow[5:0];
        e.cell_column = c[5:0];
        e.last_of_band = (c + 1 == t);
        expected_cells.insert(expected_cells.size(), e);
      end
      clear_band();
    endfunction

    function void check_cell(logic [47:0] d, logic last);
      cell_avg_t e;
      logic [47:0] want;
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h last %b", $time, d, last);
        failures++;
        return;
      end
      e = expected_cells.pop_front();
      want = {4'd0, e.cell_column, e.cell_row, e.avg[3], e.avg[2], e.avg[1], e.avg[0]};
      if (d !== want || last !== e.last_of_band) begin
        $display("%0t: mismatch, expected %h last %b, actual %h last %b",
                 $time, want, e.last_of_band, d, last);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;

  cell_average_predictor cells = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  box_average_downscale DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #1s;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) cells.check_cell(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_pixel(bit [31:0] pix);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cells.note_pixel(pix);
  endtask

  // Hold the sender off until every expected word has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (cells.expected_cells.size() != 0) @(posedge clk_i);
    // A pixel that ends no band may still be in flight.
    repeat (500) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cells.write_reg(idx, v);
  endtask

  task automatic setup(logic [12:0] w, logic [12:0] h, logic [12:0] t, logic [12:0] nc);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_THUMB, t);
    write_reg(REG_COMPS, nc);
  endtask

  task automatic send_random(int unsigned n);
    for (int i = 0; i < n; i++) begin
      send_pixel($urandom());
      if ($urandom_range(99) < 3) drain();
    end
  endtask

  initial begin
    int unsigned w, h, t, nc, n, sent;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a few pixels at reset settings, then extremes of every field.
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    setup(4, 2, 2, 4);
    for (int i = 0; i < 8; i++) send_pixel(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000);
    // Thumbnail wider than the image leaves empty cells.
    setup(2, 1, 4, 1);
    send_pixel(32'hA5A5_A5A5);
    send_pixel(32'h5A5A_5A5A);
    // Taller thumbnail than image skips cell rows; zero counts saturate up.
    setup(0, 2, 4, 0);
    send_pixel(32'h1234_5678);
    send_pixel(32'h8765_4321);
    // Oversized registers saturate; thumb of 127 becomes 64, 7 components become 4.
    setup(3, 1, 127, 7);
    for (int i = 0; i < 3; i++) send_pixel($urandom());
    // Huge width and zero thumb; a restart mid-row must discard the partial band.
    setup(8191, 8191, 0, 5);
    send_pixel(32'hFF00_FF00);
    setup(2, 2, 1, 2);
    send_pixel(32'h00FF_00FF);
    write_reg(REG_COMPS, 2);
    for (int i = 0; i < 4; i++) send_pixel($urandom());

    // Random images across the idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(9) == 0) begin
          w = $urandom_range(4, 1); h = $urandom_range(2, 1); t = $urandom_range(64, 9);
        end else begin
          w = $urandom_range(10, 1); h = $urandom_range(6, 1); t = $urandom_range(8, 0);
        end
        nc = $urandom_range(7, 0);
        setup(13'(w), 13'(h), 13'(t), 13'(nc));
        n = w * h;
        if ($urandom_range(9) == 0) n = $urandom_range(n, 1);
        else if ($urandom_range(9) == 0) n = 2 * n;
        send_random(n);
        sent += n;
      end
    end

    drain();
    if (cells.failures == 0 && cells.expected_cells.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
